FILE: sv/slru_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slru_pkg
// Shared constants, types and codes of the set-associative LRU cache.
// ----------------------------------------------------------------------------
package slru_pkg;

  localparam int unsigned LINES       = 64;
  localparam int unsigned BLOCK_WORDS = 16;
  localparam int unsigned ADDR_BITS   = 32;

  localparam int unsigned LINE_W = $clog2(LINES);
  localparam int unsigned WORD_W = $clog2(BLOCK_WORDS);
  localparam int unsigned CNT_W  = LINE_W + 1;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned TAG_W  = 32;
  localparam int unsigned AGE_W  = 6;
  localparam int unsigned CFG_W  = 3;
  localparam int unsigned IDX_W  = 2;

  localparam logic [AGE_W-1:0] AGE_MAX     = '1;
  localparam logic [CFG_W-1:0] OB_MAX      = CFG_W'(WORD_W);
  localparam logic [CFG_W-1:0] LB_MAX      = CFG_W'(LINE_W);
  localparam logic [CFG_W-1:0] OB_RESET    = 3'd4;
  localparam logic [CFG_W-1:0] LB_RESET    = 3'd6;
  localparam logic [CFG_W-1:0] WB_RESET    = 3'd2;

  localparam logic [IDX_W-1:0] CFG_OFFSET_BITS = 2'd0;
  localparam logic [IDX_W-1:0] CFG_LINE_BITS   = 2'd1;
  localparam logic [IDX_W-1:0] CFG_WAY_BITS    = 2'd2;

  localparam logic KIND_READ  = 1'b0;
  localparam logic KIND_WRITE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SCAN_END,
    ST_AGE,
    ST_AGE_END,
    ST_DATA,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic [AGE_W-1:0] age;
  } meta_t;

  typedef struct packed {
    logic accept;
    logic cnt_clr;
    logic issue;
    logic phase_age;
    logic set_valid;
    logic data_go;
    logic fill_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic last;
    logic fill_last;
    logic out_busy;
    logic hit;
  } sts_t;

endpackage

FILE: sv/slru_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slru_ctrl
// Access sequencer: tag scan, age update, data access or line fill, response.
// ----------------------------------------------------------------------------
module slru_ctrl import slru_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:     if (in_valid_i) state_d = ST_SCAN;
      ST_SCAN:     if (sts_i.last) state_d = ST_SCAN_END;
      ST_SCAN_END: state_d = ST_AGE;
      ST_AGE:      if (sts_i.last) state_d = ST_AGE_END;
      ST_AGE_END:  state_d = ST_DATA;
      ST_DATA:     if (sts_i.hit || sts_i.fill_last) state_d = ST_RESP;
      ST_RESP:     if (!sts_i.out_busy) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.accept  = in_valid_i;
        cmd_o.cnt_clr = in_valid_i;
      end
      ST_SCAN:     cmd_o.issue = 1'b1;
      ST_SCAN_END: cmd_o.cnt_clr = 1'b1;
      ST_AGE: begin
        cmd_o.issue     = 1'b1;
        cmd_o.phase_age = 1'b1;
      end
      ST_AGE_END: begin
        cmd_o.phase_age = 1'b1;
        cmd_o.cnt_clr   = 1'b1;
        cmd_o.set_valid = 1'b1;
      end
      ST_DATA: begin
        cmd_o.data_go   = sts_i.hit;
        cmd_o.fill_step = !sts_i.hit;
      end
      ST_RESP:     cmd_o.out_load = !sts_i.out_busy;
      default:     cmd_o = '0;
    endcase
  end

endmodule

FILE: sv/slru_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slru_dpath
// Geometry registers, tag/age memory, line valid bits, data memory, result.
// ----------------------------------------------------------------------------
module slru_dpath import slru_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [IDX_W-1:0]           cfg_index_i,
  input  logic [CFG_W-1:0]           cfg_data_i,
  input  logic                       kind_i,
  input  logic [ADDR_BITS-1:0]       address_i,
  input  logic [DATA_W-1:0]          write_value_i,
  input  cmd_t                       cmd_i,
  output sts_t                       sts_o,
  input  logic                       out_ready_i,
  output logic                       out_valid_o,
  output logic                       hit_o,
  output logic [DATA_W-1:0]          read_value_o,
  output logic                       evicted_o,
  output logic [TAG_W-1:0]           evicted_tag_o
);

  logic [CFG_W-1:0] ob_q, lb_q, wb_q;
  logic [CFG_W-1:0] ob_eff, lb_eff, wb_eff, sb_eff;
  logic [ADDR_BITS-1:0] set_shift;
  logic [LINE_W-1:0] set_idx, base_new;

  logic                  kind_q;
  logic [WORD_W-1:0]     off_q;
  logic [LINE_W-1:0]     base_q;
  logic [CNT_W-1:0]      ways_q;
  logic [TAG_W-1:0]      tag_q;
  logic [DATA_W-1:0]     wval_q;

  logic [CNT_W-1:0]      cnt_q;
  logic                  pv_q;
  logic [LINE_W-1:0]     pidx_q;
  meta_t                 meta_rd_q;
  meta_t                 meta_mem [LINES];
  logic [LINES-1:0]      valid_q;

  logic                  hit_q, empty_q;
  logic [LINE_W-1:0]     hline_q, eline_q, lline_q;
  logic [AGE_W-1:0]      hage_q, best_q;
  logic [TAG_W-1:0]      ltag_q;

  logic [DATA_W-1:0]     data_mem [LINES*BLOCK_WORDS];
  logic [DATA_W-1:0]     rdata_q;

  logic                  out_valid_q;
  logic                  hit_out_q, evicted_out_q;
  logic [DATA_W-1:0]     rval_out_q;
  logic [TAG_W-1:0]      etag_out_q;

  logic [LINE_W-1:0]     li, tline;
  logic                  v_li, evict;
  logic [AGE_W:0]        limit;
  meta_t                 meta_new;
  logic [LINE_W-1:0]     rd_addr;
  logic [DATA_W-1:0]     fill_val;

  // effective geometry; ADDR_BITS covers the full address so no masking
  always_comb begin
    ob_eff    = (ob_q > OB_MAX) ? OB_MAX : ob_q;
    lb_eff    = (lb_q > LB_MAX) ? LB_MAX : lb_q;
    wb_eff    = (wb_q > lb_eff) ? lb_eff : wb_q;
    sb_eff    = lb_eff - wb_eff;
    set_shift = address_i >> ob_eff;
    set_idx   = set_shift[LINE_W-1:0] & ~(LINE_W'('1) << sb_eff);
    base_new  = set_idx << wb_eff;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ob_q <= OB_RESET;
      lb_q <= LB_RESET;
      wb_q <= WB_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_OFFSET_BITS: ob_q <= cfg_data_i;
        CFG_LINE_BITS:   lb_q <= cfg_data_i;
        CFG_WAY_BITS:    wb_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      kind_q <= kind_i;
      off_q  <= address_i[WORD_W-1:0] & ~(WORD_W'('1) << ob_eff);
      base_q <= base_new;
      ways_q <= CNT_W'(1) << wb_eff;
      tag_q  <= address_i >> (4'(ob_eff) + 4'(sb_eff));
      wval_q <= write_value_i;
    end
  end

  // decision from the scan
  always_comb begin
    li    = base_q + pidx_q;
    v_li  = valid_q[li];
    evict = !hit_q && !empty_q;
    if (hit_q) begin
      tline = hline_q;
      limit = {1'b0, hage_q};
    end else if (empty_q) begin
      tline = eline_q;
      limit = {1'b1, AGE_W'(0)};
    end else begin
      tline = lline_q;
      limit = {1'b0, best_q};
    end
    meta_new.tag = meta_rd_q.tag;
    meta_new.age = meta_rd_q.age;
    if (li == tline) begin
      meta_new.age = '0;
      if (!hit_q) meta_new.tag = tag_q;
    end else if (v_li && ({1'b0, meta_rd_q.age} < limit) && (meta_rd_q.age != AGE_MAX)) begin
      meta_new.age = meta_rd_q.age + AGE_W'(1);
    end
    rd_addr  = base_q + cnt_q[LINE_W-1:0];
    fill_val = '0;
    if (cnt_q[WORD_W-1:0] == off_q) fill_val = (kind_q == KIND_WRITE) ? wval_q : '1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      pv_q        <= 1'b0;
      valid_q     <= '0;
      hit_q       <= 1'b0;
      empty_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pv_q <= cmd_i.issue;
      if (cmd_i.cnt_clr) begin
        cnt_q <= '0;
      end else if (cmd_i.issue || cmd_i.fill_step) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
      if (cmd_i.accept) begin
        hit_q   <= 1'b0;
        empty_q <= 1'b0;
      end else if (pv_q && !cmd_i.phase_age) begin
        if (!hit_q && v_li && meta_rd_q.tag == tag_q) hit_q <= 1'b1;
        if (!empty_q && !v_li) empty_q <= 1'b1;
      end
      if (cmd_i.set_valid) valid_q[tline] <= 1'b1;
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.issue) begin
      meta_rd_q <= meta_mem[rd_addr];
      pidx_q    <= cnt_q[LINE_W-1:0];
    end
    if (pv_q && cmd_i.phase_age) meta_mem[li] <= meta_new;
    if (pv_q && !cmd_i.phase_age) begin
      if (!hit_q && v_li && meta_rd_q.tag == tag_q) begin
        hline_q <= li;
        hage_q  <= meta_rd_q.age;
      end
      if (!empty_q && !v_li) eline_q <= li;
      if (pidx_q == '0 || meta_rd_q.age > best_q) begin
        best_q  <= meta_rd_q.age;
        lline_q <= li;
        ltag_q  <= meta_rd_q.tag;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.data_go) begin
      if (kind_q == KIND_WRITE) begin
        data_mem[{tline, off_q}] <= wval_q;
      end else begin
        rdata_q <= data_mem[{tline, off_q}];
      end
    end
    if (cmd_i.fill_step) data_mem[{tline, cnt_q[WORD_W-1:0]}] <= fill_val;
    if (cmd_i.out_load) begin
      hit_out_q     <= hit_q;
      rval_out_q    <= (hit_q && kind_q == KIND_READ) ? rdata_q : '0;
      evicted_out_q <= evict;
      etag_out_q    <= evict ? ltag_q : '0;
    end
  end

  assign sts_o.last      = (cnt_q == ways_q - CNT_W'(1));
  assign sts_o.fill_last = (cnt_q == CNT_W'(BLOCK_WORDS - 1));
  assign sts_o.out_busy  = out_valid_q && !out_ready_i;
  assign sts_o.hit       = hit_q;

  assign out_valid_o   = out_valid_q;
  assign hit_o         = hit_out_q;
  assign read_value_o  = rval_out_q;
  assign evicted_o     = evicted_out_q;
  assign evicted_tag_o = etag_out_q;

endmodule

FILE: sv/set_associative_lru_cache.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_associative_lru_cache
// Set-associative word cache with LRU replacement and runtime geometry.
// ----------------------------------------------------------------------------
// channel   dir  transfer                 payload
// s_axis    in   tvalid & tready          tdata {write_value, address}, tuser kind
// m_axis    out  tvalid & tready          tdata {evicted_tag, evicted, read_value, hit}
// cfg       in   cfg_valid & cfg_ready    cfg_index, cfg_data
//
// The tag/age memory is scanned and then updated one way a cycle, and a miss
// writes the 16 words of the line one a cycle.
// No clearing pass after reset; line valid bits clear at once.
// A stalled result holds the sequencer before it returns to idle.
// ----------------------------------------------------------------------------
module set_associative_lru_cache import slru_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [63:0]          s_axis_tdata_i,   // address[31:0], write_value[63:32]
  input  logic                 s_axis_tuser_i,   // kind
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [71:0]          m_axis_tdata_o,   // hit, read_value, evicted, evicted_tag, pad
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [IDX_W-1:0]     cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  cmd_t cmd;
  sts_t sts;
  logic hit, evicted;
  logic [DATA_W-1:0] read_value;
  logic [TAG_W-1:0]  evicted_tag;

  assign cfg_ready_o = 1'b1;

  slru_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  slru_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .kind_i        (s_axis_tuser_i),
    .address_i     (s_axis_tdata_i[31:0]),
    .write_value_i (s_axis_tdata_i[63:32]),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_ready_i   (m_axis_tready_i),
    .out_valid_o   (m_axis_tvalid_o),
    .hit_o         (hit),
    .read_value_o  (read_value),
    .evicted_o     (evicted),
    .evicted_tag_o (evicted_tag)
  );

  assign m_axis_tdata_o = {6'b0, evicted_tag, evicted, read_value, hit};

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the set-associative LRU cache: accesses are driven
// under several geometries, each transfer is predicted by a behavioural cache
// model and the results are compared field by field, with random gaps on
// both streams.
// ----------------------------------------------------------------------------
module tb;
  import slru_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 2000000;
  localparam int unsigned DRAIN_WAIT  = 200;

  typedef struct packed {
    logic        kind;
    logic [31:0] address;
    logic [31:0] write_value;
  } access_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] read_value;
    logic        evicted;
    logic [31:0] evicted_tag;
  } outcome_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [63:0] s_axis_tdata_i = '0;   // address[31:0], write_value[63:32]
  logic        s_axis_tuser_i = 1'b0; // kind
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [71:0] m_axis_tdata_o;        // hit, read_value, evicted, evicted_tag, pad
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_W-1:0] cfg_data_i = '0;

  set_associative_lru_cache i_dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // cache model state
  logic [CFG_W-1:0] cur_ob = OB_RESET, cur_lb = LB_RESET, cur_wb = WB_RESET;
  logic [31:0] tag_mem [LINES];
  logic        line_ok [LINES];
  int unsigned age_mem [LINES];
  logic [31:0] word_mem [LINES*BLOCK_WORDS];
  logic        word_ok [LINES*BLOCK_WORDS];

  access_t  pending_access [$];
  outcome_t expected_outcome [$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned sent = 0;
  logic in_taken = 1'b0;
  logic out_taken = 1'b0;

  initial begin
    for (int i = 0; i < LINES; i++) begin
      tag_mem[i] = '0; line_ok[i] = 1'b0; age_mem[i] = 0;
    end
    for (int i = 0; i < LINES*BLOCK_WORDS; i++) begin
      word_mem[i] = '0; word_ok[i] = 1'b0;
    end
  end

  function automatic void age_set(int unsigned base, int unsigned ways, int unsigned line,
                                  int unsigned limit);
    for (int unsigned i = base; i < base + ways; i++)
      if (i != line && line_ok[i] && age_mem[i] < limit && age_mem[i] < AGE_MAX)
        age_mem[i]++;
    age_mem[line] = 0;
  endfunction

  function automatic outcome_t cache_access(access_t a);
    outcome_t r;
    int unsigned ob, lb, wb, sb, ways, base, off, set_i, line, best, w;
    logic [31:0] tg;
    logic found;
    r = '0;
    ob = (cur_ob > WORD_W) ? WORD_W : cur_ob;
    lb = (cur_lb > LINE_W) ? LINE_W : cur_lb;
    wb = (cur_wb > lb) ? lb : cur_wb;
    sb = lb - wb;
    ways = 1 << wb;
    off = a.address & ((1 << ob) - 1);
    set_i = (a.address >> ob) & ((1 << sb) - 1);
    tg = a.address >> (ob + sb);
    base = set_i << wb;
    line = base;
    for (int unsigned i = base; i < base + ways; i++)
      if (!r.hit && line_ok[i] && tag_mem[i] == tg) begin
        r.hit = 1'b1; line = i;
      end
    if (r.hit) begin
      w = line * BLOCK_WORDS + off;
      if (a.kind == KIND_WRITE) begin
        word_mem[w] = a.write_value; word_ok[w] = 1'b1;
      end else begin
        r.read_value = word_ok[w] ? word_mem[w] : '0;
      end
      age_set(base, ways, line, age_mem[line]);
    end else begin
      found = 1'b0;
      for (int unsigned i = base; i < base + ways; i++)
        if (!found && !line_ok[i]) begin
          line = i; found = 1'b1;
        end
      if (!found) begin
        best = 0; line = base;
        for (int unsigned i = base; i < base + ways; i++)
          if (age_mem[i] > best) begin
            best = age_mem[i]; line = i;
          end
        r.evicted = 1'b1;
        r.evicted_tag = tag_mem[line];
        age_set(base, ways, line, age_mem[line]);
      end else begin
        age_set(base, ways, line, AGE_MAX + 1);
      end
      tag_mem[line] = tg;
      line_ok[line] = 1'b1;
      for (int unsigned i = 0; i < BLOCK_WORDS; i++) word_ok[line*BLOCK_WORDS + i] = 1'b0;
      w = line * BLOCK_WORDS + off;
      word_mem[w] = (a.kind == KIND_WRITE) ? a.write_value : 32'hFFFF_FFFF;
      word_ok[w] = 1'b1;
    end
    return r;
  endfunction

  // sampling at the rising edge
  always @(posedge clk_i) begin
    access_t a;
    outcome_t got, exp_o, pred;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("set_associative_lru_cache test failed");
      $finish;
    end
    in_taken <= s_axis_tvalid_i && s_axis_tready_o;
    out_taken <= m_axis_tvalid_o && m_axis_tready_i;
    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_OFFSET_BITS: cur_ob = cfg_data_i;
        CFG_LINE_BITS:   cur_lb = cfg_data_i;
        CFG_WAY_BITS:    cur_wb = cfg_data_i;
        default: ;
      endcase
    end
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      a.kind = s_axis_tuser_i;
      a.address = s_axis_tdata_i[31:0];
      a.write_value = s_axis_tdata_i[63:32];
      pred = cache_access(a);
      expected_outcome = {expected_outcome, pred};
    end
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      got.hit = m_axis_tdata_o[0];
      got.read_value = m_axis_tdata_o[32:1];
      got.evicted = m_axis_tdata_o[33];
      got.evicted_tag = m_axis_tdata_o[65:34];
      if (expected_outcome.size() == 0) begin
        $error("result transfer with no access outstanding");
        errors++;
      end else begin
        exp_o = expected_outcome[0];
        expected_outcome.delete(0);
        if (got.hit !== exp_o.hit) begin
          $error("hit: expected %0d actual %0d", exp_o.hit, got.hit); errors++;
        end
        if (got.read_value !== exp_o.read_value) begin
          $error("read_value: expected %h actual %h", exp_o.read_value, got.read_value);
          errors++;
        end
        if (got.evicted !== exp_o.evicted) begin
          $error("evicted: expected %0d actual %0d", exp_o.evicted, got.evicted); errors++;
        end
        if (got.evicted_tag !== exp_o.evicted_tag) begin
          $error("evicted_tag: expected %h actual %h", exp_o.evicted_tag, got.evicted_tag);
          errors++;
        end
      end
    end
  end

  // stimulus and sink driven at the falling edge
  always @(negedge clk_i) begin
    logic quiet;
    access_t a;
    quiet = (sent >= 300 && sent < 450);
    if (rst_ni) begin
      if (!s_axis_tvalid_i || in_taken) begin
        if (pending_access.size() != 0 && (quiet || $urandom_range(0, 99) >= 8)) begin
          a = pending_access[0];
          pending_access.delete(0);
          s_axis_tdata_i <= {a.write_value, a.address};
          s_axis_tuser_i <= a.kind;
          s_axis_tvalid_i <= 1'b1;
          sent <= sent + 1;
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
      m_axis_tready_i <= quiet || $urandom_range(0, 99) >= 8;
    end
  end

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(negedge clk_i);
    cfg_index_i <= idx;
    cfg_data_i <= val;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain();
    wait (pending_access.size() == 0 && !s_axis_tvalid_i && expected_outcome.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  function automatic void queue_access(logic kind, logic [31:0] addr, logic [31:0] val);
    access_t a;
    a.kind = kind; a.address = addr; a.write_value = val;
    pending_access = {pending_access, a};
  endfunction

  function automatic void queue_random(int unsigned n);
    logic [31:0] hi_pool [4];
    logic [31:0] addr;
    hi_pool[0] = 32'h0; hi_pool[1] = 32'hFFFF_F000;
    hi_pool[2] = {$urandom()} & 32'hFFFF_F000; hi_pool[3] = 32'h0000_5000;
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) < 8)
        addr = hi_pool[$urandom_range(0, 3)] | ($urandom_range(0, 3) << 8)
               | $urandom_range(0, 255);
      else
        addr = $urandom();
      queue_access(1'($urandom_range(0, 1)), addr, $urandom());
    end
  endfunction

  initial begin
    logic [CFG_W-1:0] geo [7][3];
    geo = '{'{3'd4, 3'd6, 3'd2}, '{3'd0, 3'd0, 3'd0}, '{3'd4, 3'd6, 3'd6},
            '{3'd7, 3'd7, 3'd7}, '{3'd1, 3'd5, 3'd0}, '{3'd2, 3'd3, 3'd1},
            '{3'd3, 3'd6, 3'd3}};
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // default geometry: extremes, hits, a full set and an eviction
    queue_access(KIND_READ, 32'h0, 32'h0);
    queue_access(KIND_READ, 32'h0, 32'h0);
    queue_access(KIND_WRITE, 32'h3, 32'h8000_0000);
    queue_access(KIND_READ, 32'h3, 32'h0);
    queue_access(KIND_READ, 32'h5, 32'h0);
    queue_access(KIND_WRITE, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
    queue_access(KIND_READ, 32'hFFFF_FFFF, 32'h0);
    queue_access(KIND_READ, 32'hFFFF_FFF0, 32'h0);
    for (int t = 1; t <= 5; t++) queue_access(KIND_WRITE, t << 8, 32'hFFFF_FFFF - t);
    queue_access(KIND_READ, 32'h0, 32'h0);
    queue_access(KIND_READ, 32'h100, 32'h0);
    queue_access(KIND_READ, 32'h500, 32'h0);
    queue_access(KIND_WRITE, 32'h600, 32'h1234_5678);
    queue_access(KIND_READ, 32'h200, 32'h0);
    queue_random(90);
    drain();

    for (int p = 1; p < 7; p++) begin
      write_reg(CFG_OFFSET_BITS, geo[p][0]);
      write_reg(CFG_LINE_BITS, geo[p][1]);
      write_reg(CFG_WAY_BITS, geo[p][2]);
      queue_random(105);
      drain();
    end

    if (errors == 0) begin
      $display("set_associative_lru_cache test passed");
    end else begin
      $display("set_associative_lru_cache test failed");
    end
    $finish;
  end

endmodule
